// File: hdl/sav_pkg.sv
`default_nettype none
package sav_pkg;

  // Instruction codes
  localparam logic [5:0] OP_LLA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_JSR  = 6'd3;
  localparam logic [5:0] OP_BZ   = 6'd4;
  localparam logic [5:0] OP_BNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PSH  = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_EXIT = 6'd38;

  // Run status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_EXIT  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_PC  = 2'd0;
  localparam logic [1:0] CFG_STACK_TOP = 2'd1;

  localparam logic [18:0] STACK_TOP_RST = 19'h40000;

  typedef struct packed {
    logic [5:0]         opcode;
    logic signed [63:0] operand;
    logic               restart;
  } in_t;

  typedef struct packed {
    logic [14:0]        next_pc;
    logic signed [63:0] accumulator;
    logic [1:0]         status;
    logic signed [63:0] exit_value;
    logic [31:0]        step_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic rd1;
    logic rd2;
    logic cap_x;
    logic cap_y;
    logic it_start;
    logic it_step;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_rd1;
    logic need_rd2;
    logic need_iter;
    logic iter_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/sav_ctrl.sv
`default_nettype none
module sav_ctrl
  import sav_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output ctl_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RD1, S_CAP1, S_RD2, S_CAP2, S_ISTART, S_ITER, S_EXEC
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DEC;
      S_DEC:    state_d = sts_i.need_rd1 ? S_RD1 : S_EXEC;
      S_RD1:    state_d = S_CAP1;
      S_CAP1: begin
        priority if (sts_i.need_rd2) state_d = S_RD2;
        else if (sts_i.need_iter)    state_d = S_ISTART;
        else                         state_d = S_EXEC;
      end
      S_RD2:    state_d = S_CAP2;
      S_CAP2:   state_d = S_EXEC;
      S_ISTART: state_d = S_ITER;
      S_ITER:   if (sts_i.iter_done) state_d = S_EXEC;
      S_EXEC:   if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd1      = (state_q == S_RD1);
    cmd_o.cap_x    = (state_q == S_CAP1);
    cmd_o.rd2      = (state_q == S_RD2);
    cmd_o.cap_y    = (state_q == S_CAP2);
    cmd_o.it_start = (state_q == S_ISTART);
    cmd_o.it_step  = (state_q == S_ITER) && !sts_i.iter_done;
    cmd_o.commit   = (state_q == S_EXEC) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/sav_dp.sv
`default_nettype none
module sav_dp
  import sav_pkg::*;
#(
  parameter int DATA_WORDS = 32768,
  parameter int CODE_WORDS = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_t         in_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [18:0] cfg_data_i,
  input  wire ctl_cmd_t    cmd_i,
  output dp_sts_t          sts_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_o
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [14:0] PcMask = 15'((CODE_WORDS - 1) & 32'h7FFF);

  function automatic logic [AW-1:0] wi(input logic [63:0] a);
    return a[AW+2:3];
  endfunction

  function automatic logic [14:0] fix_pc(input logic [63:0] v);
    return v[14:0] & PcMask;
  endfunction

  function automatic logic [63:0] sext8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  // Configuration
  logic [14:0] start_pc_q;
  logic [18:0] stack_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q  <= '0;
      stack_top_q <= STACK_TOP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START_PC)  start_pc_q  <= cfg_data_i[14:0];
      if (cfg_idx_i == CFG_STACK_TOP) stack_top_q <= cfg_data_i;
    end
  end

  // Latched item
  logic [5:0]  op_q;
  logic [63:0] imm_q;
  logic        restart_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= in_i.opcode;
      imm_q     <= in_i.operand;
      restart_q <= in_i.restart;
    end
  end

  // Architectural state
  logic [14:0] pc_q, pc_d;
  logic [18:0] sp_q, sp_d, bp_q, bp_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  st_q, st_d;
  logic [31:0] cnt_q, cnt_d;
  logic [63:0] x_q, y_q;

  logic active;
  assign active = !restart_q && (st_q == ST_RUN);

  logic is_binop, is_divmod;
  assign is_binop  = (op_q >= OP_OR) && (op_q <= OP_MOD);
  assign is_divmod = (op_q == OP_DIV) || (op_q == OP_MOD);

  // Data memory, single port, registered read
  logic [63:0]   mem [DATA_WORDS];
  logic [63:0]   rdata_q;
  logic          mem_re, mem_we, wr_req;
  logic [AW-1:0] raddr, waddr;
  logic [63:0]   wdata;

  always_comb begin
    raddr = wi(64'(sp_q));
    if (cmd_i.rd2) begin
      raddr = (op_q == OP_LEV) ? wi(64'(19'(bp_q + 19'd8))) : wi(x_q);
    end else if (op_q == OP_LEV) begin
      raddr = wi(64'(bp_q));
    end else if (op_q == OP_LI || op_q == OP_LC) begin
      raddr = wi(acc_q);
    end
  end

  assign mem_re = cmd_i.rd1 || cmd_i.rd2;
  assign mem_we = cmd_i.commit && wr_req;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_x) x_q <= rdata_q;
    if (cmd_i.cap_y) y_q <= rdata_q;
  end

  // Shared bit-serial unit: shift-add multiply, restoring divide
  logic [63:0] it_a_q, it_b_q, it_r_q;
  logic [6:0]  it_cnt_q;
  logic [63:0] ux, ua, div_t;
  logic        div_ge;

  assign ux     = x_q[63] ? (64'd0 - x_q) : x_q;
  assign ua     = acc_q[63] ? (64'd0 - acc_q) : acc_q;
  assign div_t  = {it_r_q[62:0], it_a_q[63]};
  assign div_ge = (div_t >= it_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.it_start) begin
      it_r_q <= '0;
      if (op_q == OP_MUL) begin
        it_a_q <= x_q;
        it_b_q <= acc_q;
      end else begin
        it_a_q <= ux;
        it_b_q <= ua;
      end
    end else if (cmd_i.it_step) begin
      if (op_q == OP_MUL) begin
        if (it_b_q[0]) it_r_q <= it_r_q + it_a_q;
        it_a_q <= {it_a_q[62:0], 1'b0};
        it_b_q <= {1'b0, it_b_q[63:1]};
      end else begin
        it_r_q <= div_ge ? (div_t - it_b_q) : div_t;
        it_a_q <= {it_a_q[62:0], div_ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_cnt_q <= '0;
    end else if (cmd_i.it_start) begin
      it_cnt_q <= 7'd64;
    end else if (cmd_i.it_step) begin
      it_cnt_q <= it_cnt_q - 7'd1;
    end
  end

  // Status to controller
  always_comb begin
    sts_o.need_rd1  = active && (op_q == OP_LEV || op_q == OP_LI || op_q == OP_LC ||
                      op_q == OP_SI || op_q == OP_SC || op_q == OP_EXIT || is_binop);
    sts_o.need_rd2  = active && (op_q == OP_LEV || op_q == OP_SC);
    sts_o.need_iter = active && (op_q == OP_MUL || (is_divmod && acc_q != '0));
    sts_o.iter_done = (it_cnt_q == '0);
    sts_o.out_free  = !out_valid_o || !out_stall_i;
  end

  // Commit: next architectural state
  logic [63:0] pc1, pc2, npc, exit_v;
  logic [18:0] sp_m8;
  logic [5:0]  sh;
  logic [63:0] lane_mask, q_s, r_s;

  assign pc1   = 64'(pc_q) + 64'd1;
  assign pc2   = 64'(pc_q) + 64'd2;
  assign sp_m8 = sp_q - 19'd8;
  assign sh    = {x_q[2:0], 3'b000};
  assign lane_mask = ~(64'hFF << sh);
  assign q_s   = (x_q[63] != acc_q[63]) ? (64'd0 - it_a_q) : it_a_q;
  assign r_s   = x_q[63] ? (64'd0 - it_r_q) : it_r_q;

  always_comb begin
    pc_d   = pc_q;
    sp_d   = sp_q;
    bp_d   = bp_q;
    acc_d  = acc_q;
    st_d   = st_q;
    cnt_d  = cnt_q;
    exit_v = '0;
    wr_req = 1'b0;
    waddr  = wi(64'(sp_m8));
    wdata  = acc_q;
    npc    = (op_q <= OP_ADJ) ? pc2 : pc1;
    if (restart_q) begin
      pc_d  = fix_pc(64'(start_pc_q));
      sp_d  = stack_top_q;
      bp_d  = stack_top_q;
      st_d  = ST_RUN;
      cnt_d = '0;
    end else if (st_q == ST_RUN) begin
      if (cnt_q != '1) cnt_d = cnt_q + 32'd1;
      if (is_binop) sp_d = sp_q + 19'd8;
      priority case (op_q)
        OP_LLA: acc_d = 64'(bp_q) + (imm_q << 3);
        OP_IMM: acc_d = imm_q;
        OP_JMP: npc = imm_q;
        OP_JSR: begin
          wr_req = 1'b1;
          wdata  = 64'(fix_pc(pc2));
          sp_d   = sp_m8;
          npc    = imm_q;
        end
        OP_BZ:  npc = (acc_q != '0) ? pc2 : imm_q;
        OP_BNZ: npc = (acc_q != '0) ? imm_q : pc2;
        OP_ENT: begin
          wr_req = 1'b1;
          wdata  = 64'(bp_q);
          bp_d   = sp_m8;
          sp_d   = sp_m8 - {imm_q[15:0], 3'b000};
        end
        OP_ADJ: sp_d = sp_q + {imm_q[15:0], 3'b000};
        OP_LEV: begin
          bp_d = x_q[18:0];
          sp_d = bp_q + 19'd16;
          npc  = y_q;
        end
        OP_LI:  acc_d = x_q;
        OP_LC:  acc_d = sext8(8'(x_q >> {acc_q[2:0], 3'b000}));
        OP_SI: begin
          wr_req = 1'b1;
          waddr  = wi(x_q);
          sp_d   = sp_q + 19'd8;
        end
        OP_SC: begin
          wr_req = 1'b1;
          waddr  = wi(x_q);
          wdata  = (y_q & lane_mask) | (64'(acc_q[7:0]) << sh);
          sp_d   = sp_q + 19'd8;
          acc_d  = sext8(acc_q[7:0]);
        end
        OP_PSH: begin
          wr_req = 1'b1;
          sp_d   = sp_m8;
        end
        OP_OR:  acc_d = x_q | acc_q;
        OP_XOR: acc_d = x_q ^ acc_q;
        OP_AND: acc_d = x_q & acc_q;
        OP_EQ:  acc_d = 64'(x_q == acc_q);
        OP_NE:  acc_d = 64'(x_q != acc_q);
        OP_LT:  acc_d = 64'($signed(x_q) < $signed(acc_q));
        OP_GT:  acc_d = 64'($signed(acc_q) < $signed(x_q));
        OP_LE:  acc_d = 64'(!($signed(acc_q) < $signed(x_q)));
        OP_GE:  acc_d = 64'(!($signed(x_q) < $signed(acc_q)));
        OP_SHL: acc_d = x_q << acc_q[5:0];
        OP_SHR: acc_d = $signed(x_q) >>> acc_q[5:0];
        OP_ADD: acc_d = x_q + acc_q;
        OP_SUB: acc_d = x_q - acc_q;
        OP_MUL: acc_d = it_r_q;
        OP_DIV, OP_MOD: begin
          if (acc_q == '0) st_d = ST_DIVZ;
          else acc_d = (op_q == OP_DIV) ? q_s : r_s;
        end
        OP_EXIT: begin
          exit_v = x_q;
          st_d   = ST_EXIT;
        end
        default: st_d = ST_UNSUP;
      endcase
      pc_d = fix_pc(npc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      sp_q  <= STACK_TOP_RST;
      bp_q  <= STACK_TOP_RST;
      acc_q <= '0;
      st_q  <= ST_RUN;
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      pc_q  <= pc_d;
      sp_q  <= sp_d;
      bp_q  <= bp_d;
      acc_q <= acc_d;
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_o.next_pc     <= pc_d;
      out_o.accumulator <= acc_d;
      out_o.status      <= st_d;
      out_o.exit_value  <= exit_v;
      out_o.step_count  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/stack_accumulator_vm_core.sv
`default_nettype none
// Execute core of an accumulator/stack machine: one fetched instruction in, one
// status item out (next pc, accumulator, status, exit value, step count). Items are
// handled one at a time through a single-port data memory with registered read:
// ALU, branch, push and restart items need no memory read, one read is needed
// by LI, LC, SI, binary ops and EXIT, and two reads by LEV and SC. MUL, DIV and
// MOD run through a shared bit-serial shift-add / restoring divide unit. The
// result register lets a new item be accepted while the previous result is
// still stalled. Data memory is not cleared at reset; words must be written
// before they are read. DATA_WORDS and CODE_WORDS must be powers of two.
module stack_accumulator_vm_core
  import sav_pkg::*;
#(
  parameter int DATA_WORDS = 32768,
  parameter int CODE_WORDS = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [18:0] cfg_data_i
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  sav_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sav_dp #(
    .DATA_WORDS (DATA_WORDS),
    .CODE_WORDS (CODE_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Accepted item keeps the core busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("core ready right after accepting an item");

  // Exit value only shows on an exit
  a_exit_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.exit_value != '0) |-> (out_o.status == ST_EXIT))
    else $error("nonzero exit value without exit status");

  // Iteration unit is never stepped past its count
  a_iter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.it_step |-> !sts.iter_done)
    else $error("iteration step after done");

  // Commit and latch never coincide
  a_commit_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.commit && cmd.latch))
    else $error("commit while taking a new item");

endmodule
`default_nettype wire
